// ----- sv/odlt_pkg.sv -----
// Shared types and constants for the odometry distance and lap tracker.
// Used by odlt_dist, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package odlt_pkg;

  localparam int POS_W     = 32;              // position field width
  localparam int STEP_W    = 32;              // step length width
  localparam int SUM_W     = 48;              // travel total width
  localparam int LAP_W     = 16;              // lap counter width
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int CNT_W     = $clog2(POS_W);   // serial step counter

  localparam logic [MODE_W-1:0] MODE_POS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAP_GOAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RADIUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_RADIUS = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic                    checkpoint_taken;
    logic signed [POS_W-1:0] checkpoint_x;
    logic signed [POS_W-1:0] checkpoint_y;
    logic [STEP_W-1:0]       step_length;
    logic [SUM_W-1:0]        distance_total;
    logic [LAP_W-1:0]        laps_done;
    logic                    near_start;
    logic                    finished;
  } out_item_t;

  // Distance result: ovf if span overflows POS_W bits or a leg is all ones.
  typedef struct packed {
    logic             ovf;
    logic [POS_W-1:0] span;
  } dist_res_t;

endpackage

// ----- sv/odlt_dist.sv -----
// Bit-serial Euclidean distance: floor(sqrt(dx^2 + dy^2)) between two points.
// Shift-add squaring then restoring square root, one bit/digit per cycle.
// Depends on odlt_pkg.
`timescale 1ns / 1ps

module odlt_dist (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [odlt_pkg::POS_W-1:0] ax,
  input  logic signed [odlt_pkg::POS_W-1:0] ay,
  input  logic signed [odlt_pkg::POS_W-1:0] bx,
  input  logic signed [odlt_pkg::POS_W-1:0] by,
  output logic                             done,
  output odlt_pkg::dist_res_t              res
);
  import odlt_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_SQRT} ustate_t;

  ustate_t              state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [POS_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic [POS_W-1:0]     mx_r, mx_nxt, my_r, my_nxt;
  logic [POS_W+1:0]     hi_r, hi_nxt;
  logic [POS_W-1:0]     lo_r, lo_nxt;
  logic [2*POS_W-1:0]   rad_r, rad_nxt;
  logic [POS_W+1:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]     root_r, root_nxt;

  logic signed [POS_W:0] diff_x, diff_y;
  logic [POS_W:0]        abs_x, abs_y;
  logic [POS_W+2:0]      mul_sum;
  logic [POS_W+3:0]      rem_sh, trial, rem_sub;
  logic                  last;

  always_comb begin
    diff_x = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
    diff_y = {ay[POS_W-1], ay} - {by[POS_W-1], by};
    abs_x  = diff_x[POS_W] ? -diff_x : diff_x;
    abs_y  = diff_y[POS_W] ? -diff_y : diff_y;
    abs_x  = {1'b0, abs_x[POS_W-1:0]};
    abs_y  = {1'b0, abs_y[POS_W-1:0]};

    mul_sum = {1'b0, hi_r}
            + {3'b000, (mx_r[0] ? dx_r : {POS_W{1'b0}})}
            + {3'b000, (my_r[0] ? dy_r : {POS_W{1'b0}})};

    rem_sh  = {rem_r, rad_r[2*POS_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    rem_sub = rem_sh - trial;
    last    = (cnt_r == CNT_W'(POS_W - 1));

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    ovf_nxt   = ovf_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rad_nxt   = rad_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;

    case (state_r)
      U_IDLE: begin
        if (start) begin
          dx_nxt    = abs_x[POS_W-1:0];
          dy_nxt    = abs_y[POS_W-1:0];
          mx_nxt    = abs_x[POS_W-1:0];
          my_nxt    = abs_y[POS_W-1:0];
          // a leg of all ones is already out of range
          ovf_nxt   = (&abs_x[POS_W-1:0]) | (&abs_y[POS_W-1:0]);
          hi_nxt    = '0;
          lo_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        hi_nxt  = mul_sum[POS_W+2:1];
        lo_nxt  = {mul_sum[0], lo_r[POS_W-1:1]};
        mx_nxt  = mx_r >> 1;
        my_nxt  = my_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          rad_nxt   = {hi_nxt[POS_W-1:0], lo_nxt};
          ovf_nxt   = ovf_r | (|hi_nxt[POS_W+1:POS_W]);
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = U_SQRT;
        end
      end
      U_SQRT: begin
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sub[POS_W+1:0];
          root_nxt = {root_r[POS_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[POS_W+1:0];
          root_nxt = {root_r[POS_W-2:0], 1'b0};
        end
        if (last) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end
      end
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    ovf_r  <= ovf_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done     = done_r;
  assign res.ovf  = ovf_r;
  assign res.span = root_r;

endmodule

// ----- sv/odometry_distance_lap_tracker_top.sv -----
// Top level of the odometry distance and lap tracker.
// Depends on odlt_pkg and odlt_dist.
`timescale 1ns / 1ps

// Takes position updates, checkpoint ticks and start commands, one result per
// transaction. Position updates, start commands and ticks that take no
// distance pass through the execute and result states to the output register;
// a tick that measures a step also waits for the two bit-serial distance units
// (shift-add squaring, then restoring square root; step and distance-to-start
// run side by side). One transaction is in work at a time; a new one is
// accepted while the previous result waits in the output register. Distances
// are floor(sqrt(dx^2+dy^2)) in raw position units; the travel total and lap
// count saturate. Config writes are expected only while the block is idle.
module odometry_distance_lap_tracker_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  odlt_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output odlt_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [odlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odlt_pkg::CFG_W-1:0]      cfg_data
);
  import odlt_pkg::*;

  localparam logic [STEP_W-1:0] NEAR_RESET  =
    STEP_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [STEP_W-1:0] LEAVE_RESET =
    STEP_W'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIST, ST_RESULT} state_t;

  state_t                  state_r, state_nxt;
  in_item_t                item_r, item_nxt;
  logic [LAP_W-1:0]        lap_goal_r, lap_goal_nxt;
  logic [STEP_W-1:0]       near_radius_r, near_radius_nxt;
  logic [STEP_W-1:0]       leave_radius_r, leave_radius_nxt;
  logic                    have_pos_r, have_pos_nxt;
  logic                    have_start_r, have_start_nxt;
  logic                    near_r, near_nxt;
  logic signed [POS_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [POS_W-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic signed [POS_W-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [SUM_W-1:0]        travel_r, travel_nxt;
  logic [LAP_W-1:0]        laps_r, laps_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic        dist_start, step_done, home_done;
  dist_res_t   step_res, home_res;
  logic        tick_ok, slot_free;
  logic [STEP_W-1:0] step_len;
  logic [SUM_W:0]    travel_add;
  logic        home_near, home_far;

  odlt_dist u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dist_start),
    .ax    (prev_x_r),
    .ay    (prev_y_r),
    .bx    (cur_x_r),
    .by    (cur_y_r),
    .done  (step_done),
    .res   (step_res)
  );

  odlt_dist u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dist_start),
    .ax    (start_x_r),
    .ay    (start_y_r),
    .bx    (cur_x_r),
    .by    (cur_y_r),
    .done  (home_done),
    .res   (home_res)
  );

  always_comb begin
    tick_ok    = (item_r.mode == MODE_TICK) && (laps_r != lap_goal_r) && have_pos_r;
    dist_start = (state_r == ST_EXEC) && tick_ok && have_start_r;
    slot_free  = !out_valid_r || out_ready;

    step_len   = step_res.ovf ? {STEP_W{1'b1}} : step_res.span;
    travel_add = {1'b0, travel_r} + {{(SUM_W + 1 - STEP_W){1'b0}}, step_len};
    // an out-of-range distance lies beyond every radius
    home_near  = !home_res.ovf && (home_res.span <= near_radius_r);
    home_far   = home_res.ovf || (home_res.span > leave_radius_r);

    state_nxt        = state_r;
    item_nxt         = item_r;
    lap_goal_nxt     = lap_goal_r;
    near_radius_nxt  = near_radius_r;
    leave_radius_nxt = leave_radius_r;
    have_pos_nxt     = have_pos_r;
    have_start_nxt   = have_start_r;
    near_nxt         = near_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    start_x_nxt      = start_x_r;
    start_y_nxt      = start_y_r;
    prev_x_nxt       = prev_x_r;
    prev_y_nxt       = prev_y_r;
    travel_nxt       = travel_r;
    laps_nxt         = laps_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_LAP_GOAL:     lap_goal_nxt     = cfg_data[LAP_W-1:0];
        CFG_NEAR_RADIUS:  near_radius_nxt  = cfg_data[STEP_W-1:0];
        CFG_LEAVE_RADIUS: leave_radius_nxt = cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = dist_start ? ST_DIST : ST_RESULT;
      ST_DIST: begin
        if (step_done && home_done) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) begin
          out_data_nxt = '0;
          case (item_r.mode)
            MODE_POS: begin
              cur_x_nxt    = item_r.pos_x;
              cur_y_nxt    = item_r.pos_y;
              have_pos_nxt = 1'b1;
            end
            MODE_START: begin
              have_pos_nxt   = 1'b0;
              have_start_nxt = 1'b0;
              near_nxt       = 1'b0;
              travel_nxt     = '0;
              laps_nxt       = '0;
            end
            MODE_TICK: begin
              if (tick_ok) begin
                out_data_nxt.checkpoint_taken = 1'b1;
                out_data_nxt.checkpoint_x     = cur_x_r;
                out_data_nxt.checkpoint_y     = cur_y_r;
                prev_x_nxt = cur_x_r;
                prev_y_nxt = cur_y_r;
                if (!have_start_r) begin
                  start_x_nxt    = cur_x_r;
                  start_y_nxt    = cur_y_r;
                  have_start_nxt = 1'b1;
                end else begin
                  out_data_nxt.step_length = step_len;
                  travel_nxt = travel_add[SUM_W] ? {SUM_W{1'b1}} : travel_add[SUM_W-1:0];
                  if (!near_r && home_near) begin
                    if (laps_r != {LAP_W{1'b1}}) laps_nxt = laps_r + 1'b1;
                    near_nxt = 1'b1;
                  end else if (near_r && home_far) begin
                    near_nxt = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
          out_data_nxt.distance_total = travel_nxt;
          out_data_nxt.laps_done      = laps_nxt;
          out_data_nxt.near_start     = near_nxt;
          out_data_nxt.finished       = (laps_nxt == lap_goal_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      lap_goal_r     <= '0;
      near_radius_r  <= NEAR_RESET;
      leave_radius_r <= LEAVE_RESET;
      have_pos_r     <= 1'b0;
      have_start_r   <= 1'b0;
      near_r         <= 1'b0;
      travel_r       <= '0;
      laps_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      lap_goal_r     <= lap_goal_nxt;
      near_radius_r  <= near_radius_nxt;
      leave_radius_r <= leave_radius_nxt;
      have_pos_r     <= have_pos_nxt;
      have_start_r   <= have_start_nxt;
      near_r         <= near_nxt;
      travel_r       <= travel_nxt;
      laps_r         <= laps_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    start_x_r  <= start_x_nxt;
    start_y_r  <= start_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/odlt_checker.sv -----
// Port-level checks for the odometry distance and lap tracker, bound to the top.
// Depends on odlt_pkg and odometry_distance_lap_tracker_top.
`timescale 1ns / 1ps

module odlt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input odlt_pkg::out_item_t out_data
);
  import odlt_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a new result only comes out of work in progress
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a transaction in work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind odometry_distance_lap_tracker_top odlt_checker u_odlt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for odometry_distance_lap_tracker_top.
// Depends on odlt_pkg and the tracker RTL; a built-in lap tracking predictor
// is compared field by field against every result transaction.
`timescale 1ns / 1ps

module tb_top;
  import odlt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused selector, ignored

  localparam logic [CFG_W-1:0] NEAR_AT_RESET  = 32'd6554;    // 0.1 m
  localparam logic [CFG_W-1:0] LEAVE_AT_RESET = 32'd19661;   // 0.3 m
  localparam logic [SUM_W-1:0] SUM_MAX        = '1;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic [32:0] DIST_OVF            = 33'h1_0000_0000;

  localparam int STALL_LIMIT = 3000;   // cycles without any transaction
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_MAX  = 40;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int errors  = 0;
  bit no_idle = 1'b0;
  out_item_t pending_status[$];

  // tracker image
  logic [LAP_W-1:0]        lap_goal;
  logic [CFG_W-1:0]        near_r, leave_r;
  bit                      have_pos, have_origin, near;
  logic signed [POS_W-1:0] cur_x, cur_y, org_x, org_y, last_x, last_y;
  logic [SUM_W-1:0]        travel;
  logic [LAP_W-1:0]        laps;

  odometry_distance_lap_tracker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] root_floor(logic [63:0] s);
    logic [31:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = {32'd0, r} | (64'd1 << b);
      if (c * c <= s) r = c[31:0];
    end
    return r;
  endfunction

  // floor(sqrt(dx^2 + dy^2)); DIST_OVF when it cannot fit 32 bits or a leg is all ones
  function automatic logic [32:0] span_length(input logic signed [POS_W-1:0] ax, ay, bx, by);
    longint dxs, dys;
    logic [63:0] dx, dy;
    logic [64:0] s;
    dxs = longint'(ax) - longint'(bx);
    dys = longint'(ay) - longint'(by);
    dx = (dxs < 0) ? -dxs : dxs;
    dy = (dys < 0) ? -dys : dys;
    if (dx >= 64'hFFFF_FFFF || dy >= 64'hFFFF_FFFF) return DIST_OVF;
    s = {1'b0, dx * dx} + {1'b0, dy * dy};
    if (s[64]) return DIST_OVF;
    return {1'b0, root_floor(s[63:0])};
  endfunction

  function automatic void clear_track();
    have_pos = 0;
    have_origin = 0;
    near = 0;
    cur_x = '0; cur_y = '0;
    org_x = '0; org_y = '0;
    last_x = '0; last_y = '0;
    travel = '0;
    laps = '0;
  endfunction

  function automatic out_item_t track_item(in_item_t it);
    out_item_t r;
    logic [32:0] d, ds;
    logic [STEP_W-1:0] step;
    r = '0;
    case (it.mode)
      MODE_POS: begin
        cur_x = it.pos_x;
        cur_y = it.pos_y;
        have_pos = 1;
      end
      MODE_START: clear_track();
      MODE_TICK: begin
        if (laps != lap_goal && have_pos) begin
          r.checkpoint_taken = 1'b1;
          r.checkpoint_x = cur_x;
          r.checkpoint_y = cur_y;
          if (!have_origin) begin
            org_x = cur_x; org_y = cur_y;
            last_x = cur_x; last_y = cur_y;
            have_origin = 1;
          end else begin
            d = span_length(last_x, last_y, cur_x, cur_y);
            step = d[32] ? '1 : d[31:0];
            if (SUM_MAX - travel < {16'd0, step}) travel = SUM_MAX;
            else travel = travel + step;
            last_x = cur_x; last_y = cur_y;
            r.step_length = step;
            // lap decision uses the unsaturated distance to the origin
            ds = span_length(org_x, org_y, cur_x, cur_y);
            if (!near && ds <= {1'b0, near_r}) begin
              if (laps != '1) laps = laps + 1'b1;
              near = 1;
            end else if (near && ds > {1'b0, leave_r}) begin
              near = 0;
            end
          end
        end
      end
      default: ;
    endcase
    r.distance_total = travel;
    r.laps_done = laps;
    r.near_start = near;
    r.finished = (laps == lap_goal);
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LAP_GOAL:     lap_goal = val[LAP_W-1:0];
      CFG_NEAR_RADIUS:  near_r = val;
      CFG_LEAVE_RADIUS: leave_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // leaves in_valid high: the caller sends again or drops it in the same step
  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 99) < 5) gap = $urandom_range(10, 80);
      else while ($urandom_range(0, 99) < 32) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_status = {pending_status, track_item(it)};
  endtask

  task automatic send_pos(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
    in_item_t it;
    it.mode = MODE_POS;
    it.pos_x = x;
    it.pos_y = y;
    send_item(it);
  endtask

  task automatic send_mode(logic [MODE_W-1:0] m);
    in_item_t it;
    it.mode = m;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    send_item(it);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Walks a square circuit of k points per side around a random offset,
  // mixed with skipped ticks, repeated ticks, restarts and stray positions.
  task automatic run_circuit(int n_items, int side, int k, int jit);
    int sent, idx, ox, oy, t, px, py, r;
    sent = 0;
    idx = 0;
    ox = $urandom_range(0, 1 << 28) - (1 << 27);
    oy = $urandom_range(0, 1 << 28) - (1 << 27);
    while (sent < n_items) begin
      t = (idx % k) * side / k;
      case ((idx / k) % 4)
        0: begin px = t; py = 0; end
        1: begin px = side; py = t; end
        2: begin px = side - t; py = side; end
        default: begin px = 0; py = side - t; end
      endcase
      px = ox + px + int'($urandom_range(0, 2 * jit)) - jit;
      py = oy + py + int'($urandom_range(0, 2 * jit)) - jit;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_pos(px, py);
        send_mode(MODE_TICK);
        sent += 2;
        idx++;
      end else if (r < 80) begin
        send_pos(px, py);
        sent++;
        idx++;
      end else if (r < 88) begin
        send_mode(MODE_TICK);
        sent++;
      end else if (r < 92) begin
        send_mode(MODE_SPARE);
        sent++;
      end else if (r < 95) begin
        send_mode(MODE_START);
        sent++;
      end else begin
        send_pos($urandom, $urandom);
        send_mode(MODE_TICK);
        sent += 2;
      end
    end
  endtask

  task automatic test_directed_edges();
    // lap goal 0 at reset: already finished, tick ignored
    send_pos(0, 0);
    send_mode(MODE_TICK);
    wait_results();
    write_reg(CFG_LAP_GOAL, 32'd2);
    send_mode(MODE_START);
    send_mode(MODE_TICK);          // no position yet
    send_mode(MODE_SPARE);
    send_pos(0, 0);
    send_mode(MODE_TICK);          // origin
    send_mode(MODE_TICK);          // zero step, lap on the origin
    send_pos(POS_MAX, POS_MAX);
    send_mode(MODE_TICK);          // largest step that still fits
    send_pos(POS_MIN, POS_MIN);
    send_mode(MODE_TICK);          // difference too wide, step saturates
    send_pos(POS_MAX - 1, POS_MAX - 1);
    send_mode(MODE_TICK);          // sum of squares wraps 64 bits
    send_pos(3000, -3000);
    send_mode(MODE_TICK);          // second lap, finished
    send_mode(MODE_TICK);          // ignored once finished
    send_mode(MODE_START);
    send_pos(-1, 1);
    send_mode(MODE_TICK);
    send_pos(6553, 1);
    send_mode(MODE_TICK);          // exactly on the near radius
    send_pos(19660, 1);
    send_mode(MODE_TICK);          // exactly on the leave radius, stays near
    send_pos(19661, 1);
    send_mode(MODE_TICK);
    send_pos(6554, 1);
    send_mode(MODE_TICK);          // just outside the near radius
    wait_results();
  endtask

  task automatic test_lap_default_radii();
    write_reg(CFG_LAP_GOAL, 32'd3);
    write_reg(CFG_NEAR_RADIUS, NEAR_AT_RESET);
    write_reg(CFG_LEAVE_RADIUS, LEAVE_AT_RESET);
    run_circuit(300, 1 << 20, 4, 3000);
    wait_results();
  endtask

  task automatic test_exact_radii();
    write_reg(CFG_LAP_GOAL, 32'h0000_FFFF);
    write_reg(CFG_NEAR_RADIUS, 32'd0);
    write_reg(CFG_LEAVE_RADIUS, 32'd0);
    run_circuit(250, 1 << 19, 4, 0);
    wait_results();
  endtask

  task automatic test_wide_radii();
    write_reg(CFG_LAP_GOAL, 32'd1000);
    write_reg(CFG_NEAR_RADIUS, 32'hFFFF_FFFF);
    write_reg(CFG_LEAVE_RADIUS, 32'hFFFF_FFFF);
    run_circuit(200, 1 << 24, 3, 100000);
    wait_results();
  endtask

  task automatic test_random_config();
    for (int p = 0; p < 3; p++) begin
      // upper bits of the lap goal write are don't-care
      write_reg(CFG_LAP_GOAL, ($urandom & 32'hFFFF_0000) | $urandom_range(1, 20));
      write_reg(CFG_NEAR_RADIUS, $urandom_range(1000, 40000));
      write_reg(CFG_LEAVE_RADIUS, $urandom_range(0, 60000));
      run_circuit(100, $urandom_range(1 << 18, 1 << 22), $urandom_range(2, 6),
                  $urandom_range(0, 5000));
      wait_results();
    end
  endtask

  task automatic test_noise();
    in_item_t it;
    int pick;
    write_reg(CFG_LAP_GOAL, $urandom_range(1, 6));
    write_reg(CFG_NEAR_RADIUS, $urandom);
    write_reg(CFG_LEAVE_RADIUS, $urandom);
    for (int n = 0; n < 300; n++) begin
      it.mode = MODE_W'($urandom_range(0, 3));
      it.pos_x = $urandom;
      it.pos_y = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) it.pos_x = POS_MIN;
      else if (pick == 1) it.pos_x = POS_MAX;
      else if (pick == 2) it.pos_y = POS_MIN;
      else if (pick == 3) it.pos_y = POS_MAX;
      send_item(it);
    end
    wait_results();
  endtask

  task automatic test_steady_stream();
    write_reg(CFG_LAP_GOAL, 32'd40);
    write_reg(CFG_NEAR_RADIUS, NEAR_AT_RESET);
    write_reg(CFG_LEAVE_RADIUS, LEAVE_AT_RESET);
    no_idle = 1'b1;
    run_circuit(200, 1 << 20, 4, 2000);
    wait_results();
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pauses();
    for (int n = 0; n < 15; n++) begin
      run_circuit($urandom_range(1, 6), 1 << 20, 2, 3000);
      wait_results();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (errors < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : result_check
    out_item_t want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          errors++;
        end else begin
          want = pending_status.pop_front();
          check_field("checkpoint_taken", want.checkpoint_taken, out_data.checkpoint_taken);
          check_field("checkpoint_x", want.checkpoint_x, out_data.checkpoint_x);
          check_field("checkpoint_y", want.checkpoint_y, out_data.checkpoint_y);
          check_field("step_length", want.step_length, out_data.step_length);
          check_field("distance_total", want.distance_total, out_data.distance_total);
          check_field("laps_done", want.laps_done, out_data.laps_done);
          check_field("near_start", want.near_start, out_data.near_start);
          check_field("finished", want.finished, out_data.finished);
        end
      end
      if (no_idle) begin
        hold = 0;
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        hold = $urandom_range(1, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 32);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL odometry_distance_lap_tracker_top");
    $finish;
  end

  initial begin
    clear_track();
    lap_goal = '0;
    near_r = NEAR_AT_RESET;
    leave_r = LEAVE_AT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_lap_default_radii();
    test_exact_radii();
    test_wide_radii();
    test_random_config();
    test_noise();
    test_steady_stream();
    test_sender_pauses();

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_status.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_status.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS odometry_distance_lap_tracker_top");
    end else begin
      $display("FAIL odometry_distance_lap_tracker_top");
    end
    $finish;
  end

endmodule
